FILE: sv/fdf_pkg.sv
package fdf_pkg;

    // Default size of each byte store.
    localparam int BUF_BYTES_DEF = 1536;

    // Header and trailer bytes of a datagram.
    localparam logic [7:0] ID_BYTE   = 8'h9C;
    localparam logic [7:0] TYPE_BYTE = 8'hDA;
    localparam logic [7:0] STOP_BYTE = 8'h36;
    localparam logic [7:0] PART_ONE  = 8'h01;

    // Header length and byte position counter.
    localparam int          HEAD_LEN = 6;
    localparam int          POS_W    = 17;
    localparam logic [16:0] POS_MAX  = 17'h1FFFF;

    // Depth of the result queue; must be a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Input request kinds.
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_STRIP  = 1'b1;

    // Status codes. The status field is zero in strip-byte results.
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_SINGLE   = 3'd0;
    localparam logic [2:0] ST_FRAGMENT = 3'd1;
    localparam logic [2:0] ST_FRAME    = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_BUSY     = 3'd5;

    // A result as decided by the front end; the strip byte follows from the store.
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [2:0] status;
        logic       last;
    } fdf_res_t;

    // A complete result item held in the output queue.
    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic [7:0] strip_byte;
        logic       last;
    } fdf_out_t;

    // Store strobes from the front end.
    typedef struct packed {
        logic pkt_we;
        logic asm_we;
        logic rd_en;
        logic rd_sel;
    } fdf_mem_ctl_t;

endpackage

FILE: sv/fdf_store.sv
module fdf_store #(
    parameter int BUF_BYTES = fdf_pkg::BUF_BYTES_DEF,
    localparam int ADDR_W = $clog2(BUF_BYTES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fdf_pkg::fdf_mem_ctl_t mem_ctl,
    input  logic [ADDR_W-1:0]    pkt_addr,
    input  logic [ADDR_W-1:0]    asm_addr,
    input  logic [7:0]           wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [7:0]           rd_data
);

    logic [7:0] pkt_mem [BUF_BYTES];
    logic [7:0] asm_mem [BUF_BYTES];
    logic [7:0] pkt_q_reg;
    logic [7:0] asm_q_reg;
    logic       sel_reg;

    // Packet store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_ctl.pkt_we) begin
            pkt_mem[pkt_addr] <= wr_data;
        end
        if (mem_ctl.rd_en) begin
            pkt_q_reg <= pkt_mem[rd_addr];
        end
    end

    // Assembly store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_ctl.asm_we) begin
            asm_mem[asm_addr] <= wr_data;
        end
        if (mem_ctl.rd_en) begin
            asm_q_reg <= asm_mem[rd_addr];
        end
    end

    // Remember which store the pending read drains from.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else if (mem_ctl.rd_en) begin
            sel_reg <= mem_ctl.rd_sel;
        end
    end

    assign rd_data = sel_reg ? asm_q_reg : pkt_q_reg;

endmodule

FILE: sv/fdf_front.sv
module fdf_front #(
    parameter int BUF_BYTES = fdf_pkg::BUF_BYTES_DEF,
    localparam int ADDR_W = $clog2(BUF_BYTES),
    localparam int LEN_W  = $clog2(BUF_BYTES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  req_type,
    input  logic [7:0]            data_byte,
    input  logic                  datagram_end,
    output fdf_pkg::fdf_res_t     res,
    output fdf_pkg::fdf_mem_ctl_t mem_ctl,
    output logic [ADDR_W-1:0]     pkt_addr,
    output logic [ADDR_W-1:0]     asm_addr,
    output logic [ADDR_W-1:0]     rd_addr
);

    localparam int          SUM_W   = LEN_W + 1;
    localparam logic [15:0] BUF_L16 = 16'(BUF_BYTES);
    localparam logic [SUM_W-1:0] BUF_SUM = SUM_W'(BUF_BYTES);

    // Datagram parser state.
    logic [fdf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      hdr_reg, hdr_next;
    logic [15:0]               len_reg, len_next;
    logic [7:0]                pnum_reg, pnum_next;
    logic [7:0]                pcnt_reg, pcnt_next;
    logic                      stop_reg, stop_next;
    logic                      drop_reg, drop_next;
    logic [LEN_W-1:0]          asm_len_reg, asm_len_next;

    // Drain state.
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [LEN_W-1:0]          cnt_reg, cnt_next;
    logic                      dasm_reg, dasm_next;
    logic                      act_reg, act_next;

    logic                      is_data;
    logic                      is_pull;
    logic [fdf_pkg::POS_W-1:0] k;
    logic                      in_payload;
    logic                      k_lt;
    logic                      k_eq;
    logic [SUM_W-1:0]          wr_sum;
    logic                      hdr_e;
    logic                      drop_e;
    logic [15:0]               len_e;
    logic [7:0]                pnum_e;
    logic [7:0]                pcnt_e;
    logic                      stop_e;
    logic [SUM_W-1:0]          fit_sum;
    logic [2:0]                status;
    logic                      pull_last;

    assign is_data = accept && (req_type == fdf_pkg::REQ_DATA);
    assign is_pull = accept && (req_type == fdf_pkg::REQ_PULL);

    // Payload position and the tentative write address into the assembly.
    assign k          = pos_reg - fdf_pkg::POS_W'(fdf_pkg::HEAD_LEN);
    assign in_payload = (pos_reg >= fdf_pkg::POS_W'(fdf_pkg::HEAD_LEN)) && !drop_reg
                        && hdr_reg && (len_reg <= BUF_L16);
    assign k_lt       = k < {1'b0, len_reg};
    assign k_eq       = k == {1'b0, len_reg};
    assign wr_sum     = SUM_W'(asm_len_reg) + SUM_W'(k[LEN_W-1:0]);

    // Header fields as they stand after the current byte.
    always_comb begin
        hdr_e  = hdr_reg;
        drop_e = drop_reg;
        len_e  = len_reg;
        pnum_e = pnum_reg;
        pcnt_e = pcnt_reg;
        stop_e = stop_reg;
        if (pos_reg == fdf_pkg::POS_W'(0)) begin
            drop_e = act_reg;
            hdr_e  = (data_byte == fdf_pkg::ID_BYTE);
            stop_e = 1'b0;
        end else if (pos_reg == fdf_pkg::POS_W'(1)) begin
            hdr_e = hdr_reg && (data_byte == fdf_pkg::TYPE_BYTE);
        end else if (pos_reg == fdf_pkg::POS_W'(2)) begin
            len_e = {data_byte, len_reg[7:0]};
        end else if (pos_reg == fdf_pkg::POS_W'(3)) begin
            len_e = {len_reg[15:8], data_byte};
        end else if (pos_reg == fdf_pkg::POS_W'(4)) begin
            pnum_e = data_byte;
        end else if (pos_reg == fdf_pkg::POS_W'(5)) begin
            pcnt_e = data_byte;
        end else if (in_payload && k_eq) begin
            stop_e = (data_byte == fdf_pkg::STOP_BYTE);
        end
    end

    // Store strobes and addresses.
    always_comb begin
        mem_ctl        = '0;
        mem_ctl.pkt_we = is_data && in_payload && k_lt;
        mem_ctl.asm_we = is_data && in_payload && k_lt && (wr_sum < BUF_SUM);
        mem_ctl.rd_en  = is_pull && act_reg;
        mem_ctl.rd_sel = dasm_reg;
    end

    assign pkt_addr = k[ADDR_W-1:0];
    assign asm_addr = wr_sum[ADDR_W-1:0];
    assign rd_addr  = idx_reg;

    assign fit_sum   = SUM_W'(asm_len_reg) + SUM_W'(len_e[LEN_W-1:0]);
    assign pull_last = (LEN_W'(idx_reg) + LEN_W'(1)) >= cnt_reg;

    // Next-state logic for datagram bytes, the end of a datagram and pulls.
    always_comb begin
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        len_next     = len_reg;
        pnum_next    = pnum_reg;
        pcnt_next    = pcnt_reg;
        stop_next    = stop_reg;
        drop_next    = drop_reg;
        asm_len_next = asm_len_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        dasm_next    = dasm_reg;
        act_next     = act_reg;
        status       = fdf_pkg::ST_NONE;

        if (is_data) begin
            len_next  = len_e;
            pnum_next = pnum_e;
            pcnt_next = pcnt_e;
            if (datagram_end) begin
                // Judge the datagram and start a drain where it is due.
                if (drop_e) begin
                    status = fdf_pkg::ST_BUSY;
                end else if (!hdr_e || (len_e > BUF_L16) || !stop_e) begin
                    status = fdf_pkg::ST_BAD;
                end else if (pcnt_e == fdf_pkg::PART_ONE) begin
                    status    = fdf_pkg::ST_SINGLE;
                    dasm_next = 1'b0;
                    cnt_next  = len_e[LEN_W-1:0];
                    idx_next  = '0;
                    act_next  = (len_e != 16'd0);
                end else if (fit_sum <= BUF_SUM) begin
                    if (pnum_e == pcnt_e) begin
                        status       = fdf_pkg::ST_FRAME;
                        dasm_next    = 1'b1;
                        cnt_next     = fit_sum[LEN_W-1:0];
                        idx_next     = '0;
                        act_next     = (fit_sum != SUM_W'(0));
                        asm_len_next = '0;
                    end else begin
                        status       = fdf_pkg::ST_FRAGMENT;
                        asm_len_next = fit_sum[LEN_W-1:0];
                    end
                end else begin
                    status = fdf_pkg::ST_OVERFLOW;
                end
                pos_next  = '0;
                hdr_next  = 1'b1;
                stop_next = 1'b0;
                drop_next = 1'b0;
            end else begin
                hdr_next  = hdr_e;
                stop_next = stop_e;
                drop_next = drop_e;
                if (pos_reg != fdf_pkg::POS_MAX) begin
                    pos_next = pos_reg + fdf_pkg::POS_W'(1);
                end
            end
        end else if (is_pull && act_reg) begin
            idx_next = idx_reg + ADDR_W'(1);
            if (pull_last) begin
                act_next = 1'b0;
            end
        end
    end

    // Result descriptor for the back end.
    always_comb begin
        res        = '0;
        res.valid  = (is_data && datagram_end) || (is_pull && act_reg);
        res.kind   = is_pull ? fdf_pkg::KIND_STRIP : fdf_pkg::KIND_STATUS;
        res.status = status;
        res.last   = is_pull && pull_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            hdr_reg     <= 1'b1;
            len_reg     <= '0;
            pnum_reg    <= '0;
            pcnt_reg    <= '0;
            stop_reg    <= 1'b0;
            drop_reg    <= 1'b0;
            asm_len_reg <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            dasm_reg    <= 1'b0;
            act_reg     <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            hdr_reg     <= hdr_next;
            len_reg     <= len_next;
            pnum_reg    <= pnum_next;
            pcnt_reg    <= pcnt_next;
            stop_reg    <= stop_next;
            drop_reg    <= drop_next;
            asm_len_reg <= asm_len_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            dasm_reg    <= dasm_next;
            act_reg     <= act_next;
        end
    end

endmodule

FILE: sv/fdf_back.sv
module fdf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  fdf_pkg::fdf_res_t res,
    input  logic [7:0]        rd_data,
    output logic              space_ok,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int PTR_W = $clog2(fdf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fdf_pkg::QUEUE_DEPTH + 1);

    fdf_pkg::fdf_res_t stage_reg;
    fdf_pkg::fdf_out_t queue_reg [fdf_pkg::QUEUE_DEPTH];
    fdf_pkg::fdf_out_t push_item;
    fdf_pkg::fdf_out_t head;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    // Stage that holds the result while the registered store read completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else begin
            stage_reg <= res;
        end
    end

    // Merge the read data into the staged result.
    always_comb begin
        push_item            = '0;
        push_item.kind       = stage_reg.kind;
        push_item.status     = stage_reg.status;
        push_item.strip_byte = (stage_reg.kind == fdf_pkg::KIND_STRIP) ? rd_data : 8'h00;
        push_item.last       = stage_reg.last;
    end

    assign push = stage_reg.valid;
    assign pop  = m_tvalid && m_tready;

    // Room for the next item, counting the one still in the stage.
    assign space_ok = (CNT_W'(count_reg) + CNT_W'(stage_reg.valid))
                      < CNT_W'(fdf_pkg::QUEUE_DEPTH);

    // Queue pointers wrap naturally as the depth is a power of two.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries carry payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Result channel driven from the queue head.
    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != CNT_W'(0));
    assign m_tdata  = {5'b00000, head.strip_byte, head.status};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule

FILE: sv/tpm2net_frame_deframer_unit.sv
// Receiver for LED frames carried in datagrams. Datagram bytes (tuser low) and strip pulls
// (tuser high) enter on the slave channel, one transaction per cycle while tready is high; the
// final byte of each datagram (tlast) returns a status, and each pull while a frame is
// queued returns one strip byte, tlast marking the final byte of the frame. The header is
// checked and the payload written into the packet and assembly stores as the bytes
// arrive. Results pass through the result stage, beside the registered store read, and then a
// four-entry output queue that lets the input side keep going while the master side stalls.
// The stores need no clearing after reset.
module tpm2net_frame_deframer_unit #(
    parameter int BUF_BYTES = fdf_pkg::BUF_BYTES_DEF,
    localparam int ADDR_W = $clog2(BUF_BYTES)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] status_code, [10:3] strip_byte, [15:11] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] result_kind
);

    fdf_pkg::fdf_res_t     res;
    fdf_pkg::fdf_mem_ctl_t mem_ctl;
    logic [ADDR_W-1:0]     pkt_addr;
    logic [ADDR_W-1:0]     asm_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [7:0]            rd_data;
    logic                  space_ok;
    logic                  accept;

    assign s_tready = space_ok;
    assign accept   = s_tvalid && space_ok;

    // Parser and drain control.
    fdf_front #(
        .BUF_BYTES (BUF_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .req_type     (s_tuser),
        .data_byte    (s_tdata),
        .datagram_end (s_tlast),
        .res          (res),
        .mem_ctl      (mem_ctl),
        .pkt_addr     (pkt_addr),
        .asm_addr     (asm_addr),
        .rd_addr      (rd_addr)
    );

    // Packet and assembly stores.
    fdf_store #(
        .BUF_BYTES (BUF_BYTES)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mem_ctl  (mem_ctl),
        .pkt_addr (pkt_addr),
        .asm_addr (asm_addr),
        .wr_data  (s_tdata),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Result stage and output queue.
    fdf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .rd_data  (rd_data),
        .space_ok (space_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
